// File: src/ctht_pkg.sv
// Package for the cache tag hit/miss tracker: widths, defaults, op and state types.
// Used by every module of the block; no dependencies.
`default_nettype none

package ctht_pkg;

    localparam int ADDR_W         = 14;
    localparam int TAG_W          = 11;
    localparam int SET_W          = 5;
    localparam int LINE_FIELD_W   = 5;
    localparam int LINE_COUNT_DEF = 32;
    localparam int STAMP_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_DIRECT,
        KIND_ASSOC
    } ctht_kind_t;

    typedef struct packed {
        ctht_kind_t          kind;
        logic [TAG_W-1:0]    tag;
        logic [SET_W-1:0]    set_bits;
    } ctht_op_t;

    typedef struct packed {
        logic     valid;
        ctht_op_t op;
    } ctht_qout_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEARCH,
        ST_FILL
    } ctht_state_t;

endpackage

`default_nettype wire

// File: src/ctht_if.sv
// Request and response channel interfaces (valid/ready plus payload).
// Depends on ctht_pkg for field widths.
`default_nettype none

interface ctht_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [ctht_pkg::ADDR_W-1:0] address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink (input valid, input req_type, input address, output ready);
endinterface

interface ctht_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic [ctht_pkg::LINE_FIELD_W-1:0] line_index;
    logic                              evicted;

    modport source (output valid, output hit, output line_index, output evicted, input ready);
    modport sink (input valid, input hit, input line_index, input evicted, output ready);
endinterface

`default_nettype wire

// File: src/cache_tag_hit_miss_tracker_core.sv
// Top level of the cache tag hit/miss tracker: front end, request queue, back end.
// Depends on ctht_pkg, ctht_if, ctht_front, ctht_back.
//
// Usage: requests arrive on req (valid/ready, req_type, address); one response
// per request leaves on rsp (valid/ready, hit, line_index, evicted), in order.
// cfg_we/cfg_wdata write mapping_mode (0 direct, 1 fully associative LRU);
// write it only while no transaction is in flight.
// Path: an accepted request passes through the queue into the operand register,
// then the lookup writes the response register, for a clear, any direct-mode
// access, an associative hit or a fill into a free line. An associative miss
// with every line valid first runs the registered min-stamp tree search.
// Throughput: one transaction per cycle in steady state on the lookup path
// while rsp is not stalled, set by the single lookup/update state of the back
// end; an LRU eviction holds off the next transaction until its search is done.
// Reset: all lines invalid, stamps and access counter zero, mode direct.
// A stalled rsp holds its transaction; the two-entry queue keeps accepting
// requests until full, then req.ready drops.
`default_nettype none

module cache_tag_hit_miss_tracker_core #(
    parameter int LINE_COUNT = ctht_pkg::LINE_COUNT_DEF,
    parameter int STAMP_BITS = ctht_pkg::STAMP_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    ctht_req_if.sink    req,
    ctht_rsp_if.source  rsp,
    input  wire         cfg_we,
    input  wire         cfg_wdata
);
    import ctht_pkg::*;

    ctht_qout_t qout;
    logic       pop;

    ctht_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .qout      (qout),
        .pop       (pop)
    );

    ctht_back #(
        .LINE_COUNT (LINE_COUNT),
        .STAMP_BITS (STAMP_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qout  (qout),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// File: src/ctht_front.sv
// Front end: holds the mapping mode, accepts and classifies requests,
// and buffers them in a two-entry queue. Depends on ctht_pkg, ctht_if.
`default_nettype none

module ctht_front (
    input  wire                   clk,
    input  wire                   rst_n,
    ctht_req_if.sink              req,
    input  wire                   cfg_we,
    input  wire                   cfg_wdata,
    output ctht_pkg::ctht_qout_t  qout,
    input  wire                   pop
);
    import ctht_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             mode_reg;
    ctht_op_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    ctht_op_t         op_new;
    logic             push;
    logic             do_pop;

    always_comb
    begin
        op_new.set_bits = req.address[7:3];
        if (req.req_type)
        begin
            op_new.kind = KIND_CLEAR;
            op_new.tag  = req.address[13:3];
        end
        else if (mode_reg)
        begin
            op_new.kind = KIND_ASSOC;
            op_new.tag  = req.address[13:3];
        end
        else
        begin
            op_new.kind = KIND_DIRECT;
            op_new.tag  = TAG_W'(req.address[13:8]);
        end
    end

    assign req.ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = req.valid && req.ready;
    assign qout.valid = (count_reg != '0);
    assign qout.op    = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && qout.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= op_new;
        end
    end

endmodule

`default_nettype wire

// File: src/ctht_back.sv
// Back end: tag/valid/stamp store, lookup, LRU victim tree search and
// response register. Depends on ctht_pkg, ctht_if.
`default_nettype none

module ctht_back #(
    parameter int LINE_COUNT = ctht_pkg::LINE_COUNT_DEF,
    parameter int STAMP_BITS = ctht_pkg::STAMP_BITS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire ctht_pkg::ctht_qout_t qout,
    output logic                  pop,
    ctht_rsp_if.source            rsp
);
    import ctht_pkg::*;

    localparam int IDX_W = $clog2(LINE_COUNT);
    localparam int P     = 1 << IDX_W;
    localparam int LVL_W = $clog2(IDX_W + 1);
    localparam int KEY_W = STAMP_BITS + 1;

    ctht_state_t             state_reg, state_next;
    ctht_op_t                op_reg;
    logic [LINE_COUNT-1:0]   valid_reg;
    logic [TAG_W-1:0]        tag_reg   [LINE_COUNT];
    logic [STAMP_BITS-1:0]   stamp_reg [LINE_COUNT];
    logic [STAMP_BITS-1:0]   count_reg;
    logic [KEY_W-1:0]        cand_key_reg [P];
    logic [IDX_W-1:0]        cand_idx_reg [P];
    logic [KEY_W-1:0]        load_key [P];
    logic [KEY_W-1:0]        step_key [P];
    logic [IDX_W-1:0]        step_idx [P];
    logic [LVL_W-1:0]        level_reg;
    logic [IDX_W-1:0]        line_tbl [1 << SET_W];

    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic [LINE_FIELD_W-1:0] out_line_reg;
    logic                    out_evict_reg;

    logic [LINE_COUNT-1:0]   match_vec;
    logic [IDX_W-1:0]        hit_idx, free_idx, dline;
    logic                    any_hit, any_free, dhit;
    logic                    out_free, done;
    logic                    clear_all, fill_en, touch_en, cand_load, cand_step;
    logic [IDX_W-1:0]        upd_line;
    logic                    res_hit, res_evict;

    for (genvar g = 0; g < (1 << SET_W); g++)
    begin : g_tbl
        assign line_tbl[g] = IDX_W'(g % LINE_COUNT);
    end

    for (genvar g = 0; g < P; g++)
    begin : g_cand
        if (g < LINE_COUNT)
        begin : g_real
            assign load_key[g] = {1'b0, stamp_reg[g]};
        end
        else
        begin : g_pad
            assign load_key[g] = '1;
        end
        if (g < P / 2)
        begin : g_red
            assign step_key[g] = (cand_key_reg[2*g] <= cand_key_reg[2*g+1])
                                 ? cand_key_reg[2*g] : cand_key_reg[2*g+1];
            assign step_idx[g] = (cand_key_reg[2*g] <= cand_key_reg[2*g+1])
                                 ? cand_idx_reg[2*g] : cand_idx_reg[2*g+1];
        end
        else
        begin : g_keep
            assign step_key[g] = cand_key_reg[g];
            assign step_idx[g] = cand_idx_reg[g];
        end
    end

    always_comb
    begin
        for (int i = 0; i < LINE_COUNT; i++)
        begin
            match_vec[i] = valid_reg[i] && (tag_reg[i] == op_reg.tag);
        end
        hit_idx  = '0;
        free_idx = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        any_hit  = |match_vec;
        any_free = ~&valid_reg;
        dline    = line_tbl[op_reg.set_bits];
        dhit     = valid_reg[dline] && (tag_reg[dline] == op_reg.tag);
    end

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        clear_all  = 1'b0;
        fill_en    = 1'b0;
        touch_en   = 1'b0;
        cand_load  = 1'b0;
        cand_step  = 1'b0;
        upd_line   = '0;
        res_hit    = 1'b0;
        res_evict  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (qout.valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                unique case (op_reg.kind)
                    KIND_CLEAR:
                    begin
                        if (out_free)
                        begin
                            done      = 1'b1;
                            clear_all = 1'b1;
                        end
                    end
                    KIND_DIRECT:
                    begin
                        if (out_free)
                        begin
                            done      = 1'b1;
                            upd_line  = dline;
                            touch_en  = 1'b1;
                            fill_en   = !dhit;
                            res_hit   = dhit;
                            res_evict = valid_reg[dline] && !dhit;
                        end
                    end
                    KIND_ASSOC:
                    begin
                        if (any_hit)
                        begin
                            if (out_free)
                            begin
                                done     = 1'b1;
                                upd_line = hit_idx;
                                touch_en = 1'b1;
                                res_hit  = 1'b1;
                            end
                        end
                        else if (any_free)
                        begin
                            if (out_free)
                            begin
                                done     = 1'b1;
                                upd_line = free_idx;
                                touch_en = 1'b1;
                                fill_en  = 1'b1;
                            end
                        end
                        else
                        begin
                            cand_load  = 1'b1;
                            state_next = ST_SEARCH;
                        end
                    end
                    default:
                    begin
                        done = out_free;
                    end
                endcase
            end
            ST_SEARCH:
            begin
                cand_step = 1'b1;
                if (level_reg == LVL_W'(IDX_W - 1))
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (out_free)
                begin
                    done      = 1'b1;
                    upd_line  = cand_idx_reg[0];
                    touch_en  = 1'b1;
                    fill_en   = 1'b1;
                    res_evict = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (done)
        begin
            state_next = qout.valid ? ST_LOOK : ST_IDLE;
        end
    end

    assign pop = qout.valid && (state_reg == ST_IDLE || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < LINE_COUNT; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (clear_all)
            begin
                valid_reg <= '0;
                count_reg <= '0;
                for (int i = 0; i < LINE_COUNT; i++)
                begin
                    stamp_reg[i] <= '0;
                end
            end
            else
            begin
                if (fill_en)
                begin
                    valid_reg[upd_line] <= 1'b1;
                end
                if (touch_en)
                begin
                    stamp_reg[upd_line] <= count_reg;
                    if (count_reg != '1)
                    begin
                        count_reg <= count_reg + STAMP_BITS'(1);
                    end
                end
            end
            if (cand_load)
            begin
                level_reg <= '0;
            end
            else if (cand_step)
            begin
                level_reg <= level_reg + LVL_W'(1);
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= qout.op;
        end
        if (fill_en)
        begin
            tag_reg[upd_line] <= op_reg.tag;
        end
        for (int i = 0; i < P; i++)
        begin
            if (cand_load)
            begin
                cand_key_reg[i] <= load_key[i];
                cand_idx_reg[i] <= IDX_W'(i);
            end
            else if (cand_step)
            begin
                cand_key_reg[i] <= step_key[i];
                cand_idx_reg[i] <= step_idx[i];
            end
        end
        if (done)
        begin
            out_hit_reg   <= res_hit;
            out_line_reg  <= LINE_FIELD_W'(upd_line);
            out_evict_reg <= res_evict;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.line_index = out_line_reg;
    assign rsp.evicted    = out_evict_reg;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking bench for cache_tag_hit_miss_tracker_core: direct and LRU-associative lookups,
// clears, mode changes; results checked against an in-bench tag store model.
// Depends on ctht_pkg, ctht_if and the core RTL.
module tb;

    import ctht_pkg::*;

    localparam int LINES = LINE_COUNT_DEF;

    localparam bit REQ_ACCESS = 1'b0;
    localparam bit REQ_CLEAR = 1'b1;
    localparam bit MODE_DIRECT = 1'b0;
    localparam bit MODE_ASSOC = 1'b1;

    typedef struct packed {
        logic                    clr;
        logic [ADDR_W-1:0]       addr;
    } cache_req_t;

    typedef struct packed {
        logic                    hit;
        logic [LINE_FIELD_W-1:0] line;
        logic                    evicted;
    } tag_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    ctht_req_if req_ch ();
    ctht_rsp_if rsp_ch ();

    cache_tag_hit_miss_tracker_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // tag store model
    bit                          assoc_mode;
    logic [TAG_W-1:0]            line_tag [LINES];
    bit                          line_valid [LINES];
    logic [STAMP_BITS_DEF-1:0]   line_stamp [LINES];
    logic [STAMP_BITS_DEF-1:0]   access_cnt;

    cache_req_t  req_backlog [$];
    tag_result_t due_results [$];

    bit  req_fire;
    bit  tx_quiet;
    bit  rx_quiet;
    int  burst_left;
    int  gap_left;
    int  hold_req;
    int  hold_ack;
    int  hold_left;
    logic [15:0] stall_pat;
    int  pat_pos;

    int  errors;
    int  n_req;
    int  n_clear;
    int  n_rsp;
    int  n_hit;
    int  n_evict;

    function automatic void clear_store();
        for (int i = 0; i < LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_stamp[i] = '0;
        end
        access_cnt = '0;
    endfunction

    function automatic tag_result_t cache_lookup(input logic clr, input logic [ADDR_W-1:0] a);
        tag_result_t      r;
        logic [TAG_W-1:0] t;
        int unsigned      ln;
        bit               found;
        r = '0;
        ln = 0;
        found = 1'b0;
        if (clr == REQ_CLEAR)
        begin
            clear_store();
            return r;
        end
        if (assoc_mode == MODE_DIRECT)
        begin
            ln = {27'b0, a[7:3]};
            t = {5'b0, a[13:8]};
            if (line_valid[ln] && line_tag[ln] == t)
            begin
                r.hit = 1'b1;
            end
            else
            begin
                r.evicted = line_valid[ln];
                line_valid[ln] = 1'b1;
                line_tag[ln] = t;
            end
        end
        else
        begin
            t = a[13:3];
            for (int i = 0; i < LINES; i++)
            begin
                if (!found && line_valid[i] && line_tag[i] == t)
                begin
                    found = 1'b1;
                    ln = i;
                end
            end
            if (found)
            begin
                r.hit = 1'b1;
            end
            else
            begin
                for (int i = 0; i < LINES; i++)
                begin
                    if (!found && !line_valid[i])
                    begin
                        found = 1'b1;
                        ln = i;
                    end
                end
                if (!found)
                begin
                    ln = 0;
                    for (int i = 1; i < LINES; i++)
                    begin
                        if (line_stamp[i] < line_stamp[ln])
                            ln = i;
                    end
                    r.evicted = 1'b1;
                end
                line_valid[ln] = 1'b1;
                line_tag[ln] = t;
            end
        end
        line_stamp[ln] = access_cnt;
        if (access_cnt != '1)
            access_cnt = access_cnt + 1'b1;
        r.line = ln[LINE_FIELD_W-1:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // sender: bursts with random gaps, holds a transaction until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_fire)
        begin
        end
        else if (gap_left > 0 && !tx_quiet)
        begin
            gap_left--;
            req_ch.valid <= 1'b0;
        end
        else if (req_backlog.size() > 0)
        begin
            req_ch.valid <= 1'b1;
            req_ch.req_type <= req_backlog[0].clr;
            req_ch.address <= req_backlog[0].addr;
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // receiver: random stall pattern, plus long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_ack != hold_req)
        begin
            hold_ack = hold_req;
            hold_left = 80;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rx_quiet)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= stall_pat[pat_pos];
            pat_pos++;
            if (pat_pos == 16)
            begin
                pat_pos = 0;
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                       : (16'($urandom) | 16'h0001);
            end
        end
    end

    // monitor: predict on request transaction, check on response transaction
    always @(posedge clk)
    begin
        tag_result_t got;
        tag_result_t want;
        req_fire = rst_n && req_ch.valid && req_ch.ready;
        if (req_fire)
        begin
            due_results.push_back(cache_lookup(req_ch.req_type, req_ch.address));
            void'(req_backlog.pop_front());
            n_req++;
            if (req_ch.req_type == REQ_CLEAR)
                n_clear++;
        end
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.hit = rsp_ch.hit;
            got.line = rsp_ch.line_index;
            got.evicted = rsp_ch.evicted;
            n_rsp++;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result hit=%0d line=%0d evicted=%0d",
                             $realtime, got.hit, got.line, got.evicted);
            end
            else
            begin
                want = due_results.pop_front();
                n_hit += int'(want.hit);
                n_evict += int'(want.evicted);
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result %0d expected hit=%0d line=%0d evicted=%0d, got hit=%0d line=%0d evicted=%0d",
                                 $realtime, n_rsp, want.hit, want.line, want.evicted,
                                 got.hit, got.line, got.evicted);
                end
            end
        end
    end

    task automatic push_req(input logic clr, input logic [ADDR_W-1:0] a);
        cache_req_t r;
        r.clr = clr;
        r.addr = a;
        req_backlog.push_back(r);
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || due_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_mode(input bit m);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we <= 1'b0;
        assoc_mode = m;
        @(posedge clk);
    endtask

    // working set sized around the line count so hits, fills and evictions all occur
    task automatic queue_random(input int count, input bit assoc, input bit noisy);
        logic [TAG_W-1:0]  pool [48];
        logic [2:0]        off;
        logic [4:0]        row;
        logic [ADDR_W-1:0] a;
        int                pool_n;
        int                roll;
        pool_n = $urandom_range(24, 48);
        for (int k = 0; k < 48; k++)
            pool[k] = TAG_W'($urandom);
        for (int n = 0; n < count; n++)
        begin
            roll = noisy ? $urandom_range(0, 99) : 99;
            off = 3'($urandom_range(0, 7));
            row = 5'($urandom_range(0, 31));
            if (roll < 2)
            begin
                a = ADDR_W'($urandom);
                push_req(REQ_CLEAR, a);
            end
            else if (roll < 12)
            begin
                a = ADDR_W'($urandom);
                push_req(REQ_ACCESS, a);
            end
            else if (assoc)
            begin
                push_req(REQ_ACCESS, {pool[$urandom_range(0, pool_n - 1)], off});
            end
            else
            begin
                push_req(REQ_ACCESS, {pool[$urandom_range(0, 2)][5:0], row, off});
            end
        end
    endtask

    initial
    begin
        bit ph_mode;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ACCESS;
        req_ch.address = '0;
        rsp_ch.ready = 1'b0;
        assoc_mode = MODE_DIRECT;
        for (int i = 0; i < LINES; i++)
            line_tag[i] = '0;
        clear_store();
        req_fire = 1'b0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        burst_left = 0;
        gap_left = 0;
        hold_req = 0;
        hold_ack = 0;
        hold_left = 0;
        stall_pat = 16'hB6D5;
        pat_pos = 0;
        errors = 0;
        n_req = 0;
        n_clear = 0;
        n_rsp = 0;
        n_hit = 0;
        n_evict = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // direct mode: fills, hits, conflicts, clear
        set_mode(MODE_DIRECT);
        push_req(REQ_ACCESS, 14'h0000);
        push_req(REQ_ACCESS, 14'h0007);
        push_req(REQ_ACCESS, 14'h3FFF);
        push_req(REQ_ACCESS, 14'h3FF8);
        push_req(REQ_ACCESS, 14'h0100);
        push_req(REQ_ACCESS, 14'h0000);
        push_req(REQ_ACCESS, 14'h0008);
        push_req(REQ_ACCESS, 14'h0010);
        push_req(REQ_CLEAR, 14'h3FFF);
        push_req(REQ_ACCESS, 14'h0000);
        push_req(REQ_ACCESS, 14'h0008);
        wait_idle();

        // associative without clear: duplicate tags resolve to lowest line
        set_mode(MODE_ASSOC);
        push_req(REQ_ACCESS, 14'h0003);
        push_req(REQ_ACCESS, 14'h3FFF);
        push_req(REQ_ACCESS, 14'h3FF8);
        push_req(REQ_ACCESS, 14'h1555);
        push_req(REQ_CLEAR, 14'h2AAA);
        push_req(REQ_ACCESS, 14'h0008);
        wait_idle();

        // back to direct: tag written in associative mode is compared as it stands
        set_mode(MODE_DIRECT);
        push_req(REQ_ACCESS, 14'h0100);
        push_req(REQ_ACCESS, 14'h0100);
        push_req(REQ_CLEAR, 14'h0000);
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            ph_mode = (ph % 3 == 1) ? MODE_DIRECT : MODE_ASSOC;
            tx_quiet = (ph == 3);
            rx_quiet = (ph == 3);
            set_mode(ph_mode);
            if ($urandom_range(0, 1) == 1)
                push_req(REQ_CLEAR, 14'h0000);
            queue_random(250, ph_mode, 1'b1);
            if (ph == 1)
                hold_req++;
            wait_idle();
        end

        // clean runs in each mode with a steady sender and receiver
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        set_mode(MODE_DIRECT);
        push_req(REQ_CLEAR, 14'h0000);
        queue_random(150, MODE_DIRECT, 1'b0);
        wait_idle();
        set_mode(MODE_ASSOC);
        queue_random(150, MODE_ASSOC, 1'b0);
        wait_idle();

        $display("Covered %0d requests (%0d clears) over both mapping modes and mode changes,",
                 n_req, n_clear);
        $display("with %0d hits and %0d evictions under stalls and bursts; %0d mismatches.",
                 n_hit, n_evict, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #25000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/ctht_pkg.sv
src/ctht_if.sv
src/ctht_front.sv
src/ctht_back.sv
src/cache_tag_hit_miss_tracker_core.sv
tb/tb.sv
